### hdl/aabb_pair_collision_table_unit_macros.svh
// Assertion macros for the rectangle collision table unit.
// Used by the checker; expects clk and rst_n in scope.
`ifndef AABB_PAIR_COLLISION_TABLE_UNIT_MACROS_SVH
`define AABB_PAIR_COLLISION_TABLE_UNIT_MACROS_SVH

// same-cycle implication
`define APCT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define APCT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/apct_pkg.sv
// Shared types and constants of the rectangle collision table unit.
// No dependencies.
`default_nettype none

package apct_pkg;

  localparam int BOX_W   = 62;
  localparam int KIND_W  = 3;
  localparam int ENTRY_W = BOX_W + KIND_W + 1;

  localparam logic [63:0] TYPE_MATRIX_RST = 64'd4415301485568;

  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_SWEEP  = 2'd2;

  localparam logic [2:0] ST_ADDED   = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_REMOVED = 3'd2;
  localparam logic [2:0] ST_REPORT  = 3'd3;
  localparam logic [2:0] ST_DONE    = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SWEEP
  } ctrl_state_t;

  typedef struct packed {
    logic capture;
    logic do_add;
    logic do_remove;
    logic sweep_start;
    logic sweep_run;
    logic push_done;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       sel_ok;
    logic       out_free;
    logic       drained;
  } dp_stat_t;

  // strict overlap of two packed boxes {height, width, top, left}
  function automatic logic boxes_overlap(input logic [BOX_W-1:0] a,
                                         input logic [BOX_W-1:0] b);
    logic signed [16:0] ax, ay, aw, ah, bx, by, bw, bh;
    ax = {a[15], a[15:0]};
    ay = {a[31], a[31:16]};
    aw = {2'b00, a[46:32]};
    ah = {2'b00, a[61:47]};
    bx = {b[15], b[15:0]};
    by = {b[31], b[31:16]};
    bw = {2'b00, b[46:32]};
    bh = {2'b00, b[61:47]};
    return (ax < bx + bw) && (ax + aw > bx) && (ay < by + bh) && (ay + ah > by);
  endfunction

endpackage

`default_nettype wire

### hdl/apct_ram.sv
// Generic RAM: one write port, two registered read ports with read enable.
// No dependencies.
`default_nettype none

module apct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem_r[raddr_a];
      rdata_b <= mem_r[raddr_b];
    end
  end

endmodule

`default_nettype wire

### hdl/apct_ctrl.sv
// Controller state machine of the collision table unit.
// Depends on apct_pkg.
`default_nettype none

module apct_ctrl import apct_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire dp_stat_t  stat,
  output ctrl_cmd_t      cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        unique case (stat.action)
          ACT_ADD: begin
            if (stat.out_free) state_nxt = S_IDLE;
          end
          ACT_REMOVE: begin
            if (!stat.sel_ok || stat.out_free) state_nxt = S_IDLE;
          end
          ACT_SWEEP: begin
            state_nxt = S_SWEEP;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_SWEEP: begin
        if (stat.drained && stat.out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready        = 1'b0;
    cmd             = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_EXEC: begin
        cmd.do_add      = (stat.action == ACT_ADD) && stat.out_free;
        cmd.do_remove   = (stat.action == ACT_REMOVE) && stat.sel_ok && stat.out_free;
        cmd.sweep_start = (stat.action == ACT_SWEEP);
      end
      S_SWEEP: begin
        cmd.sweep_run = 1'b1;
        cmd.push_done = stat.drained && stat.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

### hdl/apct_dpath.sv
// Datapath: request register, occupancy bits, slot RAM, pair sweep pipeline,
// output register. Depends on apct_pkg and apct_ram.
`default_nettype none

module apct_dpath import apct_pkg::*; #(
  parameter int NUM_SLOTS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire ctrl_cmd_t   cmd,
  output dp_stat_t         stat,
  input  wire logic [1:0]  in_action,
  input  wire logic [2:0]  in_slot_sel,
  input  wire logic [15:0] in_rect_left,
  input  wire logic [15:0] in_rect_top,
  input  wire logic [14:0] in_rect_width,
  input  wire logic [14:0] in_rect_height,
  input  wire logic [2:0]  in_kind_code,
  input  wire logic        in_has_handler,
  input  wire logic [63:0] type_matrix,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [2:0]       out_slot_self,
  output logic [2:0]       out_slot_other,
  output logic             out_last
);

  localparam int IW = $clog2(NUM_SLOTS);

  // request register
  logic [1:0]        act_r, act_nxt;
  logic [2:0]        sel_r, sel_nxt;
  logic [BOX_W-1:0]  box_r, box_nxt;
  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic              hdl_r, hdl_nxt;

  logic [NUM_SLOTS-1:0] used_r, used_nxt;

  // pair issue and pipeline
  logic [IW-1:0] pi_r, pi_nxt, pk_r, pk_nxt;
  logic          pend_r, pend_nxt;
  logic          s1_v_r, s1_v_nxt;
  logic [IW-1:0] s1_i_r, s1_i_nxt, s1_k_r, s1_k_nxt;
  logic          rep_ik_r, rep_ik_nxt, rep_ki_r, rep_ki_nxt;
  logic [IW-1:0] s2_i_r, s2_i_nxt, s2_k_r, s2_k_nxt;

  // output register
  logic       oval_r, oval_nxt;
  logic [2:0] ost_r, ost_nxt, oself_r, oself_nxt, oother_r, oother_nxt;
  logic       olast_r, olast_nxt;

  logic               out_free, advance, issue, free_found, sel_ok, wr_en;
  logic [IW-1:0]      free_idx, sel_idx;
  logic [ENTRY_W-1:0] rd_a, rd_b;
  logic               ovl, allow_ik, allow_ki;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int j = NUM_SLOTS - 1; j >= 0; j--) begin
      if (!used_r[j]) begin
        free_found = 1'b1;
        free_idx   = IW'(j);
      end
    end
  end

  assign sel_ok   = {1'b0, sel_r} < 4'(NUM_SLOTS);
  assign sel_idx  = sel_r[IW-1:0];
  assign out_free = !oval_r || out_ready;
  assign advance  = cmd.sweep_run && !rep_ik_r && !rep_ki_r;
  assign issue    = advance && pend_r;
  assign wr_en    = cmd.do_add && free_found;

  apct_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_SLOTS)
  ) u_ram (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (free_idx),
    .wdata   ({hdl_r, kind_r, box_r}),
    .re      (issue),
    .raddr_a (pi_r),
    .raddr_b (pk_r),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  assign ovl      = boxes_overlap(rd_a[BOX_W-1:0], rd_b[BOX_W-1:0]);
  assign allow_ik = type_matrix[{rd_a[BOX_W +: KIND_W], rd_b[BOX_W +: KIND_W]}];
  assign allow_ki = type_matrix[{rd_b[BOX_W +: KIND_W], rd_a[BOX_W +: KIND_W]}];

  always_comb begin
    act_nxt    = act_r;
    sel_nxt    = sel_r;
    box_nxt    = box_r;
    kind_nxt   = kind_r;
    hdl_nxt    = hdl_r;
    used_nxt   = used_r;
    pi_nxt     = pi_r;
    pk_nxt     = pk_r;
    pend_nxt   = pend_r;
    s1_v_nxt   = s1_v_r;
    s1_i_nxt   = s1_i_r;
    s1_k_nxt   = s1_k_r;
    rep_ik_nxt = rep_ik_r;
    rep_ki_nxt = rep_ki_r;
    s2_i_nxt   = s2_i_r;
    s2_k_nxt   = s2_k_r;
    ost_nxt    = ost_r;
    oself_nxt  = oself_r;
    oother_nxt = oother_r;
    olast_nxt  = olast_r;
    oval_nxt   = out_ready ? 1'b0 : oval_r;

    if (cmd.capture) begin
      act_nxt  = in_action;
      sel_nxt  = in_slot_sel;
      box_nxt  = {in_rect_height, in_rect_width, in_rect_top, in_rect_left};
      kind_nxt = in_kind_code;
      hdl_nxt  = in_has_handler;
    end

    if (cmd.do_add) begin
      oval_nxt   = 1'b1;
      oother_nxt = 3'd0;
      olast_nxt  = 1'b1;
      if (free_found) begin
        used_nxt[free_idx] = 1'b1;
        ost_nxt            = ST_ADDED;
        oself_nxt          = 3'(free_idx);
      end else begin
        ost_nxt   = ST_FULL;
        oself_nxt = 3'd0;
      end
    end

    if (cmd.do_remove) begin
      used_nxt[sel_idx] = 1'b0;
      oval_nxt          = 1'b1;
      ost_nxt           = ST_REMOVED;
      oself_nxt         = sel_r;
      oother_nxt        = 3'd0;
      olast_nxt         = 1'b1;
    end

    if (cmd.sweep_start) begin
      pi_nxt   = '0;
      pk_nxt   = IW'(1);
      pend_nxt = 1'b1;
    end

    if (issue) begin
      if (pk_r == IW'(NUM_SLOTS - 1)) begin
        if (pi_r == IW'(NUM_SLOTS - 2)) begin
          pend_nxt = 1'b0;
        end else begin
          pi_nxt = pi_r + IW'(1);
          pk_nxt = pi_r + IW'(2);
        end
      end else begin
        pk_nxt = pk_r + IW'(1);
      end
    end

    if (advance) begin
      s1_v_nxt   = issue && used_r[pi_r] && used_r[pk_r];
      s1_i_nxt   = pi_r;
      s1_k_nxt   = pk_r;
      rep_ik_nxt = s1_v_r && ovl && allow_ik && rd_a[ENTRY_W-1];
      rep_ki_nxt = s1_v_r && ovl && allow_ki && rd_b[ENTRY_W-1];
      s2_i_nxt   = s1_i_r;
      s2_k_nxt   = s1_k_r;
    end else if (cmd.sweep_run && out_free) begin
      oval_nxt   = 1'b1;
      ost_nxt    = ST_REPORT;
      olast_nxt  = 1'b0;
      if (rep_ik_r) begin
        rep_ik_nxt = 1'b0;
        oself_nxt  = 3'(s2_i_r);
        oother_nxt = 3'(s2_k_r);
      end else begin
        rep_ki_nxt = 1'b0;
        oself_nxt  = 3'(s2_k_r);
        oother_nxt = 3'(s2_i_r);
      end
    end

    if (cmd.push_done) begin
      oval_nxt   = 1'b1;
      ost_nxt    = ST_DONE;
      oself_nxt  = 3'd0;
      oother_nxt = 3'd0;
      olast_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r   <= '0;
      pend_r   <= 1'b0;
      s1_v_r   <= 1'b0;
      rep_ik_r <= 1'b0;
      rep_ki_r <= 1'b0;
      oval_r   <= 1'b0;
    end else begin
      used_r   <= used_nxt;
      pend_r   <= pend_nxt;
      s1_v_r   <= s1_v_nxt;
      rep_ik_r <= rep_ik_nxt;
      rep_ki_r <= rep_ki_nxt;
      oval_r   <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r    <= act_nxt;
    sel_r    <= sel_nxt;
    box_r    <= box_nxt;
    kind_r   <= kind_nxt;
    hdl_r    <= hdl_nxt;
    pi_r     <= pi_nxt;
    pk_r     <= pk_nxt;
    s1_i_r   <= s1_i_nxt;
    s1_k_r   <= s1_k_nxt;
    s2_i_r   <= s2_i_nxt;
    s2_k_r   <= s2_k_nxt;
    ost_r    <= ost_nxt;
    oself_r  <= oself_nxt;
    oother_r <= oother_nxt;
    olast_r  <= olast_nxt;
  end

  assign stat.action   = act_r;
  assign stat.sel_ok   = sel_ok;
  assign stat.out_free = out_free;
  assign stat.drained  = !pend_r && !s1_v_r && !rep_ik_r && !rep_ki_r;

  assign out_valid      = oval_r;
  assign out_status     = ost_r;
  assign out_slot_self  = oself_r;
  assign out_slot_other = oother_r;
  assign out_last       = olast_r;

endmodule

`default_nettype wire

### hdl/aabb_pair_collision_table_unit.sv
// Top level of the rectangle collision table unit: APB type matrix register,
// controller and datapath. Depends on apct_pkg, apct_ctrl, apct_dpath.
//
//   channel | handshake          | payload
//   --------+--------------------+---------------------------------------------
//   in      | in_valid/in_ready  | action, slot_sel, rect box, kind, handler
//   out     | out_valid/out_ready| status, slot_self, slot_other, last
//   cfg     | psel/penable/pready| type_matrix at byte address 0, 64 bits
//
// Add and remove: request capture, then table update into the output register.
// A sweep streams slot pairs through the two-port slot RAM, one pair per cycle
// while no collision report is waiting for the output register.
// Synchronous reset empties the table and loads the default type matrix.
// A stalled output holds its request; a report waiting on it freezes the sweep.
`default_nettype none

module aabb_pair_collision_table_unit import apct_pkg::*; #(
  parameter int NUM_SLOTS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_action,
  input  wire logic [2:0]  in_slot_sel,
  input  wire logic [15:0] in_rect_left,
  input  wire logic [15:0] in_rect_top,
  input  wire logic [14:0] in_rect_width,
  input  wire logic [14:0] in_rect_height,
  input  wire logic [2:0]  in_kind_code,
  input  wire logic        in_has_handler,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [2:0]       out_slot_self,
  output logic [2:0]       out_slot_other,
  output logic             out_last,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  logic [63:0] matrix_r, matrix_nxt;
  ctrl_cmd_t   cmd;
  dp_stat_t    stat;

  assign pready = 1'b1;

  always_comb begin
    matrix_nxt = matrix_r;
    if (psel && penable && pwrite && !paddr[3]) matrix_nxt = pwdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      matrix_r <= TYPE_MATRIX_RST;
    end else begin
      matrix_r <= matrix_nxt;
    end
  end

  assign prdata = paddr[3] ? 64'd0 : matrix_r;

  apct_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  apct_dpath #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_action      (in_action),
    .in_slot_sel    (in_slot_sel),
    .in_rect_left   (in_rect_left),
    .in_rect_top    (in_rect_top),
    .in_rect_width  (in_rect_width),
    .in_rect_height (in_rect_height),
    .in_kind_code   (in_kind_code),
    .in_has_handler (in_has_handler),
    .type_matrix    (matrix_r),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_slot_self  (out_slot_self),
    .out_slot_other (out_slot_other),
    .out_last       (out_last)
  );

endmodule

`default_nettype wire

### hdl/apct_checker.sv
// Port-level checker for the collision table unit, bound to the top level.
// Depends on apct_pkg and aabb_pair_collision_table_unit_macros.svh.
`default_nettype none
`include "aabb_pair_collision_table_unit_macros.svh"

module apct_checker import apct_pkg::*; (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] out_status,
  input wire logic [2:0] out_slot_self,
  input wire logic [2:0] out_slot_other,
  input wire logic       out_last
);

  `APCT_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_slot_self) && $stable(out_slot_other) && $stable(out_last), "stalled result changed")
  `APCT_ASSERT_IMP(a_status_range, out_valid, out_status <= ST_DONE, "status code out of range")
  `APCT_ASSERT_IMP(a_last_match, out_valid, out_last == (out_status != ST_REPORT), "last flag does not match status")
  `APCT_ASSERT_IMP(a_other_zero, out_valid && out_status != ST_REPORT, out_slot_other == 3'd0, "other slot set outside a report")
  `APCT_ASSERT_IMP(a_pair_distinct, out_valid && out_status == ST_REPORT, out_slot_self != out_slot_other, "report pairs a slot with itself")

endmodule

bind aabb_pair_collision_table_unit apct_checker u_apct_checker (.*);

`default_nettype wire

### sim/tb_aabb_pair_collision_table_unit.sv
// Testbench of the rectangle collision table unit: directed and random requests,
// each result checked in order against an in-bench model of the slot table.
// Depends on apct_pkg and aabb_pair_collision_table_unit.
module tb_aabb_pair_collision_table_unit import apct_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          SLOTS            = 8;
  localparam logic [1:0]  ACT_IGNORED      = 2'd3;
  localparam logic [3:0]  ADDR_TYPE_MATRIX = 4'd0;
  localparam int          SETTLE_CYCLES    = 120;
  localparam int          LONG_HOLD        = 300;
  localparam int          CYCLE_LIMIT      = 1_500_000;

  typedef struct {
    logic [1:0]         action;
    logic [2:0]         slot_sel;
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic [14:0]        width;
    logic [14:0]        height;
    logic [2:0]         kind;
    logic               handler;
  } table_request_t;

  typedef struct packed {
    logic [2:0] status;
    logic [2:0] slot_self;
    logic [2:0] slot_other;
    logic       last;
  } table_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid, in_ready;
  logic [1:0] in_action;
  logic [2:0] in_slot_sel;
  logic [15:0] in_rect_left, in_rect_top;
  logic [14:0] in_rect_width, in_rect_height;
  logic [2:0] in_kind_code;
  logic in_has_handler;
  logic out_valid, out_ready;
  logic [2:0] out_status, out_slot_self, out_slot_other;
  logic out_last;
  logic psel, penable, pwrite, pready;
  logic [3:0] paddr;
  logic [63:0] pwdata, prdata;

  // table model
  bit                 occupied    [SLOTS];
  logic signed [15:0] box_left    [SLOTS];
  logic signed [15:0] box_top     [SLOTS];
  logic [14:0]        box_width   [SLOTS];
  logic [14:0]        box_height  [SLOTS];
  logic [2:0]         box_kind    [SLOTS];
  bit                 box_reports [SLOTS];
  logic [63:0]        matrix_copy;

  table_result_t pending_results[$];
  int error_count = 0;
  int cycle_count = 0;
  bit send_idle = 1'b1;
  bit recv_idle = 1'b1;
  bit hold_output = 1'b0;

  aabb_pair_collision_table_unit #(.NUM_SLOTS(SLOTS)) dut (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_action, .in_slot_sel, .in_rect_left, .in_rect_top,
    .in_rect_width, .in_rect_height, .in_kind_code, .in_has_handler,
    .out_valid, .out_ready, .out_status, .out_slot_self, .out_slot_other, .out_last,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bit rects_intersect(int a, int b);
    int ax, ay, aw, ah, bx, by, bw, bh;
    ax = box_left[a];
    ay = box_top[a];
    aw = box_width[a];
    ah = box_height[a];
    bx = box_left[b];
    by = box_top[b];
    bw = box_width[b];
    bh = box_height[b];
    return ax < bx + bw && ax + aw > bx && ay < by + bh && ay + ah > by;
  endfunction

  function automatic bit reports_against(int self, int other);
    return matrix_copy[{box_kind[self], box_kind[other]}] && box_reports[self];
  endfunction

  function automatic void queue_result(logic [2:0] status, logic [2:0] self,
                                       logic [2:0] other, logic last);
    table_result_t res;
    res.status     = status;
    res.slot_self  = self;
    res.slot_other = other;
    res.last       = last;
    pending_results.push_back(res);
  endfunction

  function automatic void predict_table_response(table_request_t req);
    int slot;
    slot = -1;
    case (req.action)
      ACT_ADD: begin
        for (int i = 0; i < SLOTS; i++)
          if (!occupied[i] && slot < 0) slot = i;
        if (slot < 0) begin
          queue_result(ST_FULL, 3'd0, 3'd0, 1'b1);
        end else begin
          occupied[slot]    = 1'b1;
          box_left[slot]    = req.left;
          box_top[slot]     = req.top;
          box_width[slot]   = req.width;
          box_height[slot]  = req.height;
          box_kind[slot]    = req.kind;
          box_reports[slot] = req.handler;
          queue_result(ST_ADDED, 3'(slot), 3'd0, 1'b1);
        end
      end
      ACT_REMOVE: begin
        if (req.slot_sel < SLOTS) begin
          occupied[req.slot_sel] = 1'b0;
          queue_result(ST_REMOVED, req.slot_sel, 3'd0, 1'b1);
        end
      end
      ACT_SWEEP: begin
        for (int i = 0; i < SLOTS; i++)
          for (int k = i + 1; k < SLOTS; k++)
            if (occupied[i] && occupied[k] && rects_intersect(i, k)) begin
              if (reports_against(i, k)) queue_result(ST_REPORT, 3'(i), 3'(k), 1'b0);
              if (reports_against(k, i)) queue_result(ST_REPORT, 3'(k), 3'(i), 1'b0);
            end
        queue_result(ST_DONE, 3'd0, 3'd0, 1'b1);
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, logic [2:0] want, logic [2:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    table_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d slot_self %0d slot_other %0d",
               out_status, out_slot_self, out_slot_other);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, out_status);
        check_field("slot_self", want.slot_self, out_slot_self);
        check_field("slot_other", want.slot_other, out_slot_other);
        check_field("last", want.last, out_last);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_aabb_pair_collision_table_unit: errors");
      $finish;
    end
  end

  initial begin
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_output) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_ready <= 1'b1;
        hold_output = 1'b0;
      end else if (recv_idle && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_request(table_request_t req);
    if (send_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= req.action;
    in_slot_sel    <= req.slot_sel;
    in_rect_left   <= req.left;
    in_rect_top    <= req.top;
    in_rect_width  <= req.width;
    in_rect_height <= req.height;
    in_kind_code   <= req.kind;
    in_has_handler <= req.handler;
    do @(posedge clk); while (!in_ready);
    predict_table_response(req);
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // optional write, then read back
  task automatic cfg_access(bit do_write, logic [63:0] value);
    if (do_write) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_TYPE_MATRIX;
      pwdata  <= value;
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      matrix_copy = value;
    end
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_TYPE_MATRIX;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== matrix_copy) begin
      $error("type_matrix: expected %h, got %h", matrix_copy, prdata);
      error_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic table_request_t add_request(int left, int top, int width, int height,
                                                 int kind, bit handler);
    table_request_t req;
    req.action   = ACT_ADD;
    req.slot_sel = 3'($urandom_range(0, 7));
    req.left     = 16'(left);
    req.top      = 16'(top);
    req.width    = 15'(width);
    req.height   = 15'(height);
    req.kind     = 3'(kind);
    req.handler  = handler;
    return req;
  endfunction

  function automatic table_request_t op_request(logic [1:0] action, int sel);
    table_request_t req;
    req = add_request($urandom, $urandom, $urandom, $urandom, $urandom, $urandom_range(0, 1));
    req.action   = action;
    req.slot_sel = 3'(sel);
    return req;
  endfunction

  function automatic table_request_t random_request();
    table_request_t req;
    int pick, used;
    used = 0;
    foreach (occupied[i]) used += occupied[i];
    if ($urandom_range(0, 4) == 0)
      req = add_request($urandom, $urandom, $urandom, $urandom, $urandom, $urandom_range(0, 1));
    else
      req = add_request($urandom_range(0, 80) - 40, $urandom_range(0, 80) - 40,
                        $urandom_range(0, 40), $urandom_range(0, 40),
                        $urandom_range(0, 7), $urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 4)
      req.action = ACT_IGNORED;
    else if (pick < (used < 5 ? 55 : 30))
      req.action = ACT_ADD;
    else if (pick < 65)
      req.action = ACT_REMOVE;
    else
      req.action = ACT_SWEEP;
    if (req.action == ACT_REMOVE && used > 0 && $urandom_range(0, 3) != 0)
      do req.slot_sel = 3'($urandom_range(0, SLOTS - 1)); while (!occupied[req.slot_sel]);
    return req;
  endfunction

  task automatic test_directed();
    send_request(op_request(ACT_SWEEP, 0));
    send_request(op_request(ACT_IGNORED, 0));
    send_request(op_request(ACT_REMOVE, 5));
    send_request(add_request(0, 0, 10, 10, 2, 1'b1));
    send_request(add_request(10, 0, 5, 5, 1, 1'b1));
    send_request(add_request(10, 5, 0, 3, 3, 1'b1));
    send_request(add_request(-32768, -32768, 32767, 32767, 4, 1'b1));
    send_request(add_request(32767, 32767, 32767, 32767, 5, 1'b0));
    send_request(add_request(-5, -5, 8, 8, 4, 1'b1));
    send_request(add_request(2, 2, 3, 3, 7, 1'b1));
    send_request(add_request(0, 0, 20, 20, 6, 1'b1));
    send_request(add_request(1, 1, 1, 1, 0, 1'b0));
    send_request(op_request(ACT_SWEEP, 0));
    send_request(op_request(ACT_REMOVE, 7));
    send_request(op_request(ACT_REMOVE, 0));
    send_request(add_request(5, 5, 0, 0, 0, 1'b1));
    send_request(op_request(ACT_SWEEP, 0));
    quiesce();
  endtask

  task automatic test_register_access();
    cfg_access(1'b0, '0);
    cfg_access(1'b1, '1);
    cfg_access(1'b1, '0);
    cfg_access(1'b1, 64'hAAAA_AAAA_AAAA_AAAA);
    cfg_access(1'b1, 64'h5555_5555_5555_5555);
    cfg_access(1'b1, TYPE_MATRIX_RST);
  endtask

  task automatic test_random_traffic(int count, logic [63:0] matrix);
    cfg_access(1'b1, matrix);
    for (int n = 0; n < count; n++) begin
      if (n % 25 == 0) begin
        send_idle = $urandom_range(0, 2) != 0;
        recv_idle = $urandom_range(0, 2) != 0;
      end
      send_request(random_request());
    end
    quiesce();
  endtask

  // every pair overlaps, so each sweep yields the largest burst
  task automatic test_backpressure();
    cfg_access(1'b1, '1);
    for (int s = 0; s < SLOTS; s++) send_request(op_request(ACT_REMOVE, s));
    for (int s = 0; s < SLOTS; s++) send_request(add_request(s, -s, 10, 10, s, 1'b1));
    hold_output = 1'b1;
    repeat (6) send_request(op_request(ACT_SWEEP, 0));
    quiesce();
  endtask

  task automatic test_final_no_idle();
    send_idle = 1'b0;
    recv_idle = 1'b0;
    cfg_access(1'b1, {$urandom, $urandom});
    repeat (80) send_request(random_request());
    quiesce();
  endtask

  initial begin
    matrix_copy = TYPE_MATRIX_RST;
    foreach (occupied[i]) occupied[i] = 1'b0;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_action      <= ACT_ADD;
    in_slot_sel    <= '0;
    in_rect_left   <= '0;
    in_rect_top    <= '0;
    in_rect_width  <= '0;
    in_rect_height <= '0;
    in_kind_code   <= '0;
    in_has_handler <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_register_access();
    test_random_traffic(100, '1);
    test_random_traffic(40, '0);
    test_random_traffic(100, {$urandom, $urandom});
    test_random_traffic(60, TYPE_MATRIX_RST);
    test_backpressure();
    test_final_no_idle();

    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      error_count++;
    end
    if (error_count == 0)
      $display("tb_aabb_pair_collision_table_unit: clean");
    else
      $display("tb_aabb_pair_collision_table_unit: errors");
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/apct_pkg.sv
hdl/apct_ram.sv
hdl/apct_ctrl.sv
hdl/apct_dpath.sv
hdl/aabb_pair_collision_table_unit.sv
hdl/apct_checker.sv
sim/tb_aabb_pair_collision_table_unit.sv
